// ===== sv/lvam_pkg.sv =====
// Shared types and constants for the low voltage alarm monitor.
package lvam_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 9;
  localparam int THR_W    = 10;
  localparam int SEV_W    = 3;
  localparam int GAP_W    = 16;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 4;

  localparam int NOMINAL_CV = 1200;

  localparam int BUZZ_ON_MS      = 500;
  localparam int BUZZ_OFF_MS     = 1000;
  localparam int BUZZ_PERIOD_MS  = 60000;
  localparam int LIGHT_ON_MS     = 350;
  localparam int LIGHT_OFF_MS    = 650;
  localparam int LIGHT_PERIOD_MS = 10000;

  localparam int BUZZ_GAP_BASE  = BUZZ_OFF_MS + BUZZ_PERIOD_MS;
  localparam int BUZZ_GAP_STEP  = BUZZ_ON_MS + BUZZ_OFF_MS;
  localparam int LIGHT_GAP_BASE = LIGHT_OFF_MS + LIGHT_PERIOD_MS;
  localparam int LIGHT_GAP_STEP = LIGHT_ON_MS + LIGHT_OFF_MS;

  localparam int RECOVER_RESET = 115;
  localparam int LOWEST_RESET  = 90;
  localparam int STEP_RESET    = 5;

  localparam logic [SEV_W-1:0] SEV_NONE  = 3'd0;
  localparam logic [SEV_W-1:0] SEV_FIRST = 3'd1;
  localparam logic [SEV_W-1:0] SEV_WORST = 3'd6;

  typedef enum logic [1:0] {
    REG_RECOVER_LEVEL = 2'd0,
    REG_LOWEST_LEVEL  = 2'd1,
    REG_LEVEL_STEP    = 2'd2,
    REG_BUZZ_FIRST    = 2'd3
  } lvam_reg_t;

  typedef struct packed {
    logic [7:0] recover_level;
    logic [7:0] lowest_level;
    logic [5:0] level_step;
    logic       buzzer_at_first_level;
  } lvam_cfg_t;

endpackage

// ===== sv/lvam_if.sv =====
// Stream interfaces for sample input and result output.
interface lvam_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_centivolts;

  modport source (output valid, output sample_centivolts, input ready);
  modport sink (input valid, input sample_centivolts, output ready);
endinterface

interface lvam_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] average_centivolts;
  logic        decision_made;
  logic        alarm_stop;
  logic        alarm_start;
  logic [2:0]  severity;
  logic        buzzer_enabled;
  logic [15:0] buzzer_last_gap_ms;
  logic [15:0] light_last_gap_ms;

  modport source (
    output valid, output average_centivolts, output decision_made, output alarm_stop,
    output alarm_start, output severity, output buzzer_enabled,
    output buzzer_last_gap_ms, output light_last_gap_ms, input ready
  );
  modport sink (
    input valid, input average_centivolts, input decision_made, input alarm_stop,
    input alarm_start, input severity, input buzzer_enabled,
    input buzzer_last_gap_ms, input light_last_gap_ms, output ready
  );
endinterface

// ===== sv/lvam_regs.sv =====
// APB configuration register bank.
module lvam_regs
  import lvam_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output lvam_cfg_t         cfg
);

  lvam_reg_t reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lvam_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recover_level         <= 8'(RECOVER_RESET);
      cfg.lowest_level          <= 8'(LOWEST_RESET);
      cfg.level_step            <= 6'(STEP_RESET);
      cfg.buzzer_at_first_level <= 1'b1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RECOVER_LEVEL: cfg.recover_level         <= pwdata[7:0];
        REG_LOWEST_LEVEL:  cfg.lowest_level          <= pwdata[7:0];
        REG_LEVEL_STEP:    cfg.level_step            <= pwdata[5:0];
        REG_BUZZ_FIRST:    cfg.buzzer_at_first_level <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_RECOVER_LEVEL: prdata = CFG_DW'(cfg.recover_level);
      REG_LOWEST_LEVEL:  prdata = CFG_DW'(cfg.lowest_level);
      REG_LEVEL_STEP:    prdata = CFG_DW'(cfg.level_step);
      REG_BUZZ_FIRST:    prdata = CFG_DW'(cfg.buzzer_at_first_level);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== sv/lvam_front.sv =====
// Front end: sample ring, running sum and group-of-N detection.
module lvam_front
  import lvam_pkg::*;
#(
  parameter int RING_DEPTH = 6,
  parameter int SUM_W      = 15
) (
  input  logic                clk,
  input  logic                rst,
  lvam_sample_if.sink         sample,
  output logic                push_valid,
  output logic [SUM_W:0]      push_data,
  input  logic                push_ready
);

  localparam int POS_W = $clog2(RING_DEPTH);

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [POS_W-1:0]    pos;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic                wrap;
  logic                accept;

  assign sample.ready = push_ready;
  assign accept       = sample.valid && push_ready;
  assign wrap         = (pos == POS_W'(RING_DEPTH - 1));
  assign sum_next     = sum - SUM_W'(ring[pos]) + SUM_W'(sample.sample_centivolts);

  assign push_valid = sample.valid;
  assign push_data  = {wrap, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= SAMPLE_W'(NOMINAL_CV);
      end
      pos <= '0;
      sum <= SUM_W'(NOMINAL_CV * RING_DEPTH);
    end else if (accept) begin
      ring[pos] <= sample.sample_centivolts;
      pos       <= wrap ? '0 : pos + 1'b1;
      sum       <= sum_next;
    end
  end

endmodule

// ===== sv/lvam_fifo.sv =====
// Two-entry queue between front and back.
module lvam_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_data;
  end

endmodule

// ===== sv/lvam_back.sv =====
// Back end: average and level by reciprocal multiply, severity and alarm decisions.
module lvam_back
  import lvam_pkg::*;
#(
  parameter int RING_DEPTH = 6,
  parameter int SUM_W      = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  lvam_cfg_t      cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  logic [SUM_W:0] pop_data,
  lvam_result_if.source  result
);

  // floor(n*M >> S) is exact for n < 2**SUM_W when S >= SUM_W + clog2(divisor)
  localparam int AVG_DIV   = RING_DEPTH;
  localparam int LVL_DIV   = RING_DEPTH * 10;
  localparam int AVG_SHIFT = SUM_W + $clog2(AVG_DIV);
  localparam int LVL_SHIFT = SUM_W + $clog2(LVL_DIV);
  localparam longint AVG_MUL = ((64'd1 << AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV;
  localparam longint LVL_MUL = ((64'd1 << LVL_SHIFT) + LVL_DIV - 1) / LVL_DIV;
  localparam int AVG_PW = SUM_W + AVG_SHIFT;
  localparam int LVL_PW = SUM_W + LVL_SHIFT;

  logic              a_valid;
  logic              a_decision;
  logic [AVG_PW-1:0] a_avg_prod;
  logic [LVL_PW-1:0] a_lvl_prod;

  logic              out_free;
  logic              a_ready;
  logic              advance;

  logic [SEV_W-1:0]  cur_sev;
  logic              alarm_active;
  logic [SEV_W-1:0]  cur_sev_next;
  logic              alarm_active_next;

  logic [SAMPLE_W-1:0] avg;
  logic [LEVEL_W-1:0]  level;
  logic [THR_W-1:0]    thr [1:4];
  logic [SEV_W-1:0]    sev_map;
  logic                stop;
  logic                start;
  logic                buzz;
  logic [GAP_W-1:0]    buzz_gap;
  logic [GAP_W-1:0]    light_gap;

  assign out_free  = !result.valid || result.ready;
  assign a_ready   = !a_valid || out_free;
  assign pop_ready = a_ready;
  assign advance   = a_valid && out_free;

  // Stage A: reciprocal products, one register after the multipliers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pop_valid) begin
      a_decision <= pop_data[SUM_W];
      a_avg_prod <= AVG_PW'(pop_data[SUM_W-1:0]) * AVG_PW'(AVG_MUL);
      a_lvl_prod <= LVL_PW'(pop_data[SUM_W-1:0]) * LVL_PW'(LVL_MUL);
    end
  end

  assign avg   = a_avg_prod[AVG_SHIFT +: SAMPLE_W];
  assign level = a_lvl_prod[LVL_SHIFT +: LEVEL_W];

  always_comb begin
    for (int k = 1; k <= 4; k++) begin
      thr[k] = THR_W'(cfg.lowest_level) + THR_W'(cfg.level_step) * THR_W'(k);
    end
  end

  always_comb begin
    if (THR_W'(level) <= THR_W'(cfg.lowest_level)) sev_map = SEV_WORST;
    else if (THR_W'(level) <= thr[1])              sev_map = 3'd5;
    else if (THR_W'(level) <= thr[2])              sev_map = 3'd4;
    else if (THR_W'(level) <= thr[3])              sev_map = 3'd3;
    else if (THR_W'(level) <= thr[4])              sev_map = 3'd2;
    else                                           sev_map = SEV_FIRST;
  end

  always_comb begin
    cur_sev_next      = cur_sev;
    alarm_active_next = alarm_active;
    stop              = 1'b0;
    start             = 1'b0;
    buzz              = 1'b0;
    buzz_gap          = '0;
    light_gap         = '0;
    if (a_decision) begin
      if (level >= LEVEL_W'(cfg.recover_level)) begin
        stop              = alarm_active;
        alarm_active_next = 1'b0;
        cur_sev_next      = SEV_NONE;
      end else if (sev_map != cur_sev) begin
        cur_sev_next      = sev_map;
        stop              = alarm_active;
        alarm_active_next = 1'b1;
        start             = 1'b1;
        buzz              = (sev_map != SEV_FIRST) || cfg.buzzer_at_first_level;
        if (buzz) begin
          buzz_gap = GAP_W'(BUZZ_GAP_BASE) - GAP_W'(sev_map) * GAP_W'(BUZZ_GAP_STEP);
        end
        light_gap = GAP_W'(LIGHT_GAP_BASE) - GAP_W'(sev_map) * GAP_W'(LIGHT_GAP_STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sev      <= SEV_NONE;
      alarm_active <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (out_free) result.valid <= a_valid;
      if (advance) begin
        cur_sev      <= cur_sev_next;
        alarm_active <= alarm_active_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (advance) begin
      result.average_centivolts <= avg;
      result.decision_made      <= a_decision;
      result.alarm_stop         <= stop;
      result.alarm_start        <= start;
      result.severity           <= cur_sev_next;
      result.buzzer_enabled     <= buzz;
      result.buzzer_last_gap_ms <= buzz_gap;
      result.light_last_gap_ms  <= light_gap;
    end
  end

  a_start_has_sev: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.alarm_start |-> result.severity != SEV_NONE)
    else $error("alarm start with no severity");

  a_stop_on_decision: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.alarm_stop || result.alarm_start) |-> result.decision_made)
    else $error("alarm change outside a decision");

  a_buzz_with_start: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.buzzer_enabled |-> result.alarm_start)
    else $error("buzzer enabled without a start");

  a_active_tracks_sev: assert property (@(posedge clk) disable iff (rst)
    (cur_sev == SEV_NONE) == !alarm_active)
    else $error("alarm flag and severity disagree");

endmodule

// ===== sv/low_voltage_alarm_monitor.sv =====
// A taken sample enters the queue, then the stage A register, then the output register.
// Throughput: one sample per cycle while results are taken; the two-entry queue and the output register
// let input and output stall independently.
// Reset (rst, synchronous): ring filled with 1200 cV, sum 1200*RING_DEPTH, position 0,
// no alarm, registers at 115 / 90 / 5 / 1, queue and pipeline empty.
module low_voltage_alarm_monitor
  import lvam_pkg::*;
#(
  parameter int RING_DEPTH = 6
) (
  input  logic              clk,
  input  logic              rst,
  lvam_sample_if.sink       sample,
  lvam_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);

  lvam_cfg_t      cfg;
  logic           push_valid;
  logic           push_ready;
  logic [SUM_W:0] push_data;
  logic           pop_valid;
  logic           pop_ready;
  logic [SUM_W:0] pop_data;

  lvam_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lvam_front #(.RING_DEPTH(RING_DEPTH), .SUM_W(SUM_W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lvam_fifo #(.WIDTH(SUM_W + 1)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  lvam_back #(.RING_DEPTH(RING_DEPTH), .SUM_W(SUM_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

// ===== test/low_voltage_alarm_monitor_tb.sv =====
// Self-checking testbench for the low voltage alarm monitor: stream stimulus, APB set-up, scoreboard.
module low_voltage_alarm_monitor_tb;
  import lvam_pkg::*;

  localparam int RING_SLOTS  = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [SAMPLE_W-1:0] average_centivolts;
    logic                decision_made;
    logic                alarm_stop;
    logic                alarm_start;
    logic [SEV_W-1:0]    severity;
    logic                buzzer_enabled;
    logic [GAP_W-1:0]    buzzer_last_gap_ms;
    logic [GAP_W-1:0]    light_last_gap_ms;
  } alarm_outcome_t;

  class alarm_scoreboard;
    logic [SAMPLE_W-1:0] ring [RING_SLOTS];
    int                  slot;
    int                  sample_sum;
    logic [SEV_W-1:0]    current_sev;
    bit                  alarm_on;
    lvam_cfg_t           cfg;
    alarm_outcome_t      outcome_q [$];
    int                  faults;

    function new();
      foreach (ring[i]) ring[i] = SAMPLE_W'(NOMINAL_CV);
      slot        = 0;
      sample_sum  = NOMINAL_CV * RING_SLOTS;
      current_sev = SEV_NONE;
      alarm_on    = 1'b0;
      cfg.recover_level         = 8'(RECOVER_RESET);
      cfg.lowest_level          = 8'(LOWEST_RESET);
      cfg.level_step            = 6'(STEP_RESET);
      cfg.buzzer_at_first_level = 1'b1;
      faults = 0;
    endfunction

    function void set_register(lvam_reg_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_RECOVER_LEVEL: cfg.recover_level = value[7:0];
        REG_LOWEST_LEVEL:  cfg.lowest_level = value[7:0];
        REG_LEVEL_STEP:    cfg.level_step = value[5:0];
        REG_BUZZ_FIRST:    cfg.buzzer_at_first_level = value[0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DW-1:0] register_value(lvam_reg_t idx);
      case (idx)
        REG_RECOVER_LEVEL: return CFG_DW'(cfg.recover_level);
        REG_LOWEST_LEVEL:  return CFG_DW'(cfg.lowest_level);
        REG_LEVEL_STEP:    return CFG_DW'(cfg.level_step);
        default:           return CFG_DW'(cfg.buzzer_at_first_level);
      endcase
    endfunction

    function logic [SEV_W-1:0] severity_for_level(int level);
      int s;
      if (level <= int'(cfg.lowest_level)) return SEV_WORST;
      for (s = 5; s >= 2; s--)
        if (level <= int'(cfg.lowest_level) + (6 - s) * int'(cfg.level_step))
          return SEV_W'(s);
      return SEV_FIRST;
    endfunction

    // Runs one accepted sample through the ring and queues what the block should return.
    function void note_sample(logic [SAMPLE_W-1:0] sample);
      alarm_outcome_t   o;
      int               level;
      logic [SEV_W-1:0] sev;
      o = '{default: '0};
      sample_sum = sample_sum - int'(ring[slot]) + int'(sample);
      ring[slot] = sample;
      slot = (slot + 1) % RING_SLOTS;
      o.average_centivolts = SAMPLE_W'(sample_sum / RING_SLOTS);
      if (slot == 0) begin
        level = sample_sum / (RING_SLOTS * 10);
        o.decision_made = 1'b1;
        if (level >= int'(cfg.recover_level)) begin
          o.alarm_stop = alarm_on;
          alarm_on     = 1'b0;
          current_sev  = SEV_NONE;
        end else begin
          sev = severity_for_level(level);
          if (sev != current_sev) begin
            current_sev   = sev;
            o.alarm_stop  = alarm_on;
            alarm_on      = 1'b1;
            o.alarm_start = 1'b1;
            o.buzzer_enabled = (sev != SEV_FIRST) || cfg.buzzer_at_first_level;
            if (o.buzzer_enabled)
              o.buzzer_last_gap_ms = GAP_W'(BUZZ_GAP_BASE - int'(sev) * BUZZ_GAP_STEP);
            o.light_last_gap_ms = GAP_W'(LIGHT_GAP_BASE - int'(sev) * LIGHT_GAP_STEP);
          end
        end
      end
      o.severity = current_sev;
      outcome_q.push_back(o);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(alarm_outcome_t got);
      alarm_outcome_t want;
      if (outcome_q.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("result transaction with nothing expected: average %0d",
                   got.average_centivolts);
        return;
      end
      want = outcome_q.pop_front();
      compare("average_centivolts", want.average_centivolts, got.average_centivolts);
      compare("decision_made", want.decision_made, got.decision_made);
      compare("alarm_stop", want.alarm_stop, got.alarm_stop);
      compare("alarm_start", want.alarm_start, got.alarm_start);
      compare("severity", want.severity, got.severity);
      compare("buzzer_enabled", want.buzzer_enabled, got.buzzer_enabled);
      compare("buzzer_last_gap_ms", want.buzzer_last_gap_ms, got.buzzer_last_gap_ms);
      compare("light_last_gap_ms", want.light_last_gap_ms, got.light_last_gap_ms);
    endfunction

    function int outstanding();
      return outcome_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lvam_sample_if sample_ch ();
  lvam_result_if result_ch ();

  low_voltage_alarm_monitor #(.RING_DEPTH(RING_SLOTS)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  alarm_scoreboard     sb = new();
  logic [SAMPLE_W-1:0] sample_queue [$];
  int                  burst_left = 0;
  int                  cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver back-pressure: windows of always-ready, a rotating pattern, or heavy stalls.
  logic [15:0] stall_pattern = 16'hffff;
  int          stall_window = 0;
  int          stall_mode = 0;

  always @(negedge clk) begin
    if (stall_window == 0) begin
      stall_window  = $urandom_range(20, 120);
      stall_mode    = $urandom_range(0, 3);
      stall_pattern = 16'($urandom) | 16'h0101;
    end
    stall_window--;
    case (stall_mode)
      1: begin
        result_ch.ready = stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      2: result_ch.ready = ($urandom_range(0, 3) == 0);
      default: result_ch.ready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    alarm_outcome_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.average_centivolts = result_ch.average_centivolts;
      got.decision_made      = result_ch.decision_made;
      got.alarm_stop         = result_ch.alarm_stop;
      got.alarm_start        = result_ch.alarm_start;
      got.severity           = result_ch.severity;
      got.buzzer_enabled     = result_ch.buzzer_enabled;
      got.buzzer_last_gap_ms = result_ch.buzzer_last_gap_ms;
      got.light_last_gap_ms  = result_ch.light_last_gap_ms;
      sb.check_result(got);
    end
  end

  // Sends everything queued, in bursts with random gaps; called and left at a falling edge.
  task automatic send_queued();
    int gap;
    while (sample_queue.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          sample_ch.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      sample_ch.valid = 1'b1;
      sample_ch.sample_centivolts = sample_queue.pop_front();
      @(posedge clk);
      while (!sample_ch.ready) @(posedge clk);
      sb.note_sample(sample_ch.sample_centivolts);
      burst_left--;
      @(negedge clk);
    end
    sample_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(lvam_reg_t idx, bit is_write, logic [CFG_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = is_write;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (is_write)
      sb.set_register(idx, value);
    else
      sb.compare("register readback", sb.register_value(idx), prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_settings(lvam_cfg_t s);
    apb_access(REG_RECOVER_LEVEL, 1'b1, CFG_DW'(s.recover_level));
    apb_access(REG_LOWEST_LEVEL, 1'b1, CFG_DW'(s.lowest_level));
    apb_access(REG_LEVEL_STEP, 1'b1, CFG_DW'(s.level_step));
    apb_access(REG_BUZZ_FIRST, 1'b1, CFG_DW'(s.buzzer_at_first_level));
    apb_access(REG_RECOVER_LEVEL, 1'b0, '0);
    apb_access(REG_LEVEL_STEP, 1'b0, '0);
    apb_access(REG_BUZZ_FIRST, 1'b0, '0);
  endtask

  // Mostly whole groups of six near one level, so decisions walk through the severity
  // bands; some pure noise and some short groups that break the alignment.
  task automatic run_phase(int groups, bit hold_midway);
    int lo;
    int hi;
    int target;
    int kind;
    int n;
    int v;
    lo = int'(sb.cfg.lowest_level) - 8;
    hi = int'(sb.cfg.recover_level) + 8;
    if (lo < 0) lo = 0;
    if (hi > 409) hi = 409;
    target = $urandom_range(lo, hi);
    for (int g = 0; g < groups; g++) begin
      if (hold_midway && g == groups / 2) wait_drained();
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        repeat (RING_SLOTS) sample_queue.push_back(SAMPLE_W'($urandom_range(0, 4095)));
      end else begin
        if ($urandom_range(0, 2) != 0) target = $urandom_range(lo, hi);
        n = (kind == 1) ? $urandom_range(1, 5) : RING_SLOTS;
        repeat (n) begin
          v = target * 10 + $urandom_range(0, 9);
          if (v > 4095) v = 4095;
          sample_queue.push_back(SAMPLE_W'(v));
        end
      end
      send_queued();
    end
  endtask

  initial begin
    lvam_cfg_t settings [8];
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample_centivolts = '0;
    result_ch.ready = 1'b1;

    settings[0] = '{recover_level: 8'd115, lowest_level: 8'd90, level_step: 6'd5,
                    buzzer_at_first_level: 1'b0};
    settings[1] = '{recover_level: 8'd255, lowest_level: 8'd0, level_step: 6'd0,
                    buzzer_at_first_level: 1'b1};
    settings[2] = '{recover_level: 8'd0, lowest_level: 8'd90, level_step: 6'd5,
                    buzzer_at_first_level: 1'b1};
    settings[3] = '{recover_level: 8'd250, lowest_level: 8'd200, level_step: 6'd50,
                    buzzer_at_first_level: 1'b0};
    settings[4] = '{recover_level: 8'd255, lowest_level: 8'd255, level_step: 6'd63,
                    buzzer_at_first_level: 1'b1};
    settings[5] = '{recover_level: 8'd120, lowest_level: 8'd60, level_step: 6'd1,
                    buzzer_at_first_level: 1'b0};
    for (int i = 6; i < 8; i++) begin
      settings[i].recover_level         = 8'($urandom);
      settings[i].lowest_level          = 8'($urandom);
      settings[i].level_step            = 6'($urandom);
      settings[i].buzzer_at_first_level = 1'($urandom);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: worst severity with the field extremes, a severity change with stop
    // and start together, an unchanged severity, then recovery stopping the alarm.
    sample_queue = '{12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0,
                     12'd2500, 12'd704, 12'd704, 12'd704, 12'd704, 12'd704,
                     12'd1003, 12'd1003, 12'd1003, 12'd1003, 12'd1003, 12'd1003,
                     12'd4095, 12'd4095, 12'd1200, 12'd1200, 12'd1200, 12'd1200};
    send_queued();

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      apply_settings(settings[p]);
      run_phase(25, p == 2);
    end

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.faults == 0 && sb.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
